### rtl/core/pie_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the power iteration eigenvector engine.
// Used by every module in rtl/core except pie_ram; depends on nothing else.
package pie_pkg;

  // Field and datapath widths fixed by the item formats.
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned MAG_W    = 48;
  localparam int unsigned ITER_W   = 16;
  localparam int unsigned TOL_W    = 31;
  localparam int unsigned SIZE_W   = 7;
  localparam int unsigned POS_W    = 12;
  localparam int unsigned ACC_W    = 64;
  localparam int unsigned YMAG_W   = 63;
  localparam int unsigned SCL_W    = 28;
  localparam int unsigned DVD_W    = 58;
  localparam int unsigned QUO_W    = 31;
  localparam int unsigned ROOT_W   = 32;
  localparam int unsigned CFG_AW   = 4;
  localparam int unsigned PROD_SH  = 6;
  localparam int unsigned FRAC_SH  = 30;
  localparam int unsigned MAG_SH   = 24;

  // Register reset values and the magnitude saturation limit.
  localparam logic [SIZE_W-1:0] SIZE_RST  = 7'd64;
  localparam logic [TOL_W-1:0]  TOL_RST   = 31'd1;
  localparam logic [ITER_W-1:0] MAXIT_RST = 16'd1000;
  localparam logic [MAG_W-1:0]  MAG_SAT   = {MAG_W{1'b1}};

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_SIZE  = 2'd0,
    REG_TOL   = 2'd1,
    REG_MAXIT = 2'd2
  } reg_idx_e;

  // One input item: a matrix element.
  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    last_element;
  } in_item_t;

  // One result item: a vector element with run summary.
  typedef struct packed {
    logic signed [VAL_W-1:0] vector_element;
    logic [MAG_W-1:0]        eigen_magnitude;
    logic [ITER_W-1:0]       iterations;
    logic                    converged;
    logic                    last_result;
  } out_item_t;

  // Element of A x held in sign-magnitude form.
  typedef struct packed {
    logic              neg;
    logic [YMAG_W-1:0] mag;
  } y_t;

  // Controls broadcast to every cell of the vector chain.
  typedef struct packed {
    logic load_x;
    logic shift_x;
    logic shift_y;
  } cell_ctrl_t;

endpackage

### rtl/core/pie_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing else.
module pie_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/pie_cell.sv
`timescale 1ns / 1ps
// One cell of the vector chain: holds one element of x and one of y.
// Depends on pie_pkg.
module pie_cell (
  input  logic                           clk_i,
  input  pie_pkg::cell_ctrl_t            ctrl_i,
  input  logic                           tail_i,
  input  logic signed [pie_pkg::VAL_W-1:0] x_init_i,
  input  logic signed [pie_pkg::VAL_W-1:0] x_ins_i,
  input  logic signed [pie_pkg::VAL_W-1:0] x_next_i,
  input  pie_pkg::y_t                    y_ins_i,
  input  pie_pkg::y_t                    y_next_i,
  output logic signed [pie_pkg::VAL_W-1:0] x_o,
  output pie_pkg::y_t                    y_o
);
  import pie_pkg::*;

  logic signed [VAL_W-1:0] x_q;
  y_t                      y_q;

  // The x element loads the start value, or moves one cell toward the head;
  // the tail cell of the active ring takes the inserted value instead.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_x) begin
      x_q <= x_init_i;
    end else if (ctrl_i.shift_x) begin
      x_q <= tail_i ? x_ins_i : x_next_i;
    end
  end

  // The y element moves the same way under its own shift.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift_y) begin
      y_q <= tail_i ? y_ins_i : y_next_i;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;

endmodule

### rtl/core/pie_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, for quotients below 2^31.
// Depends on pie_pkg.
module pie_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [pie_pkg::DVD_W-1:0]    dividend_i,
  input  logic [pie_pkg::ROOT_W-1:0]   divisor_i,
  output logic                         done_o,
  output logic [pie_pkg::QUO_W-1:0]    quo_o
);
  import pie_pkg::*;

  localparam int unsigned CW = $clog2(QUO_W);

  logic              busy_q;
  logic              done_q;
  logic [CW-1:0]     cnt_q;
  logic [ROOT_W-1:0] rem_q;
  logic [ROOT_W-1:0] dvs_q;
  logic [QUO_W-1:0]  dq_q;
  logic [ROOT_W:0]   trial;
  logic [ROOT_W:0]   diff;
  logic              ge;

  // Bring down the next dividend bit and try the subtraction.
  assign trial = {rem_q, dq_q[QUO_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = (trial >= {1'b0, dvs_q});

  // Control: busy while the quotient bits form, then a done pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(QUO_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: the upper dividend bits form the starting remainder, and the
  // quotient bits replace the low dividend bits as they shift out.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= ROOT_W'(dividend_i[DVD_W-1:QUO_W]);
      dq_q  <= dividend_i[QUO_W-1:0];
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[ROOT_W-1:0] : trial[ROOT_W-1:0];
      dq_q  <= {dq_q[QUO_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = dq_q;

endmodule

### rtl/core/pie_sqrt.sv
`timescale 1ns / 1ps
// Floor square root of a 64-bit value, two radicand bits per cycle.
// Depends on pie_pkg.
module pie_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [pie_pkg::ACC_W-1:0]   radicand_i,
  output logic                        done_o,
  output logic [pie_pkg::ROOT_W-1:0]  root_o
);
  import pie_pkg::*;

  logic             busy_q;
  logic             done_q;
  logic [ACC_W-1:0] v_q;
  logic [ACC_W-1:0] res_q;
  logic [ACC_W-1:0] bit_q;
  logic [ACC_W-1:0] trial;
  logic             ge;

  assign trial = res_q + bit_q;
  assign ge    = (v_q >= trial);

  // Control: the step with the lowest bit ends the run.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q[0]) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // One digit-by-digit step per cycle.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= radicand_i;
      res_q <= '0;
      bit_q <= {2'b01, {(ACC_W - 2){1'b0}}};
    end else if (busy_q) begin
      if (ge) begin
        v_q   <= v_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[ROOT_W-1:0];

endmodule

### rtl/core/power_iteration_eigen_engine_core.sv
`timescale 1ns / 1ps
// Power iteration engine: n*n matrix items load at one per cycle while idle; the last one
// starts a run. It sets x by one division; each round does a multiply-accumulate over the
// single matrix RAM port, a normalizing shift (a zero vector ends here), squares, a square
// root and n divisions (one divider, one bit per cycle); n results follow at up to one per
// cycle. Reset clears control, configuration and the load position; the matrix RAM and
// vector chain are not cleared. Depends on pie_pkg, pie_ram, pie_cell, pie_div and pie_sqrt.
module power_iteration_eigen_engine_core #(
  parameter int unsigned MAX_DIM = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  pie_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output pie_pkg::out_item_t             out_data_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pie_pkg::CFG_AW-1:0]     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import pie_pkg::*;

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned NW    = $clog2(MAX_DIM + 1);
  localparam int unsigned IW    = $clog2(MAX_DIM);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_INIT = 9'b000000010,
    S_MV   = 9'b000000100,
    S_LOD  = 9'b000001000,
    S_SQ   = 9'b000010000,
    S_SQRT = 9'b000100000,
    S_DIV  = 9'b001000000,
    S_CHK  = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_e;

  // Configuration registers.
  logic [SIZE_W-1:0]    size_q;
  logic [TOL_W-1:0]     tol_q;
  logic [ITER_W-1:0]    maxit_q;
  logic [2*TOL_W-1:0]   tol_sq;
  logic [2*TOL_W-1:0]   tol2_q;
  logic                 cfg_wr;

  // Control state.
  state_e               state_q;
  state_e               state_d;
  logic [POS_W-1:0]     pos_q;
  logic [NW-1:0]        n_q;
  logic [NW-1:0]        n_m1;
  logic [SIZE_W-1:0]    n_cl;
  logic [IW-1:0]        row_q;
  logic [IW-1:0]        col_q;
  logic [AW-1:0]        addr_q;
  logic                 issue_q;
  logic                 rv_q, rre_q, rlast_q;
  logic                 pv_q, pre_q, plast_q;
  logic                 yv_q, ylast_q;
  logic                 mv_q, mlast_q;
  logic                 sqv_q;
  logic                 dv_wait_q;
  logic                 dv_q;
  logic                 sdv_q;
  logic [NW-1:0]        cnt_q;
  logic [ITER_W-1:0]    iter_q;
  logic                 conv_q;
  logic                 zero_q;
  logic                 out_valid_q;

  // Datapath registers.
  logic signed [ACC_W-1:0] p_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [ACC_W-1:0] yraw_q;
  logic [YMAG_W-1:0]       mag_q;
  logic [YMAG_W-1:0]       big_q;
  logic [YMAG_W-1:0]       tmp_q;
  logic [5:0]              rsh_q;
  logic [5:0]              lsh_q;
  logic [2*SCL_W-1:0]      sq_q;
  logic [ACC_W-1:0]        sum_q;
  logic [ROOT_W-1:0]       ns_q;
  logic [MAG_W-1:0]        norm_q;
  logic signed [VAL_W:0]   d_q;
  logic [ACC_W-1:0]        sqd_q;
  logic [ACC_W-1:0]        err_q;
  out_item_t               out_q;

  // Chain and unit signals.
  logic signed [VAL_W-1:0] x_cell [MAX_DIM];
  logic signed [VAL_W-1:0] x_nb   [MAX_DIM];
  y_t                      y_cell [MAX_DIM];
  y_t                      y_nb   [MAX_DIM];
  logic signed [VAL_W-1:0] x_head;
  y_t                      y_head;
  logic signed [VAL_W-1:0] x_init;
  logic signed [VAL_W-1:0] x_ins;
  y_t                      y_ins;
  cell_ctrl_t              cell_ctrl;
  logic signed [VAL_W-1:0] ram_rdata;
  logic                    ram_we;
  logic                    div_start;
  logic [DVD_W-1:0]        div_dvd;
  logic [ROOT_W-1:0]       div_dvs;
  logic                    div_done;
  logic [QUO_W-1:0]        div_quo;
  logic                    sqrt_start;
  logic                    sqrt_done;
  logic [ROOT_W-1:0]       sqrt_root;

  // Combinational helpers.
  logic                    in_fire;
  logic                    out_load;
  logic                    col_end;
  logic                    row_end;
  logic signed [ACC_W-1:0] p_sh;
  logic                    p_fix;
  logic signed [ACC_W-1:0] acc_sum;
  logic [ACC_W-1:0]        yneg;
  logic [YMAG_W-1:0]       ymag;
  logic [YMAG_W-1:0]       bigger;
  logic [YMAG_W-1:0]       sc_full;
  logic [SCL_W-1:0]        scaled;
  logic [2*SCL_W-1:0]      sc_sq;
  logic [ACC_W-1:0]        root64;
  logic [6:0]              rs_amt;
  logic [ACC_W-1:0]        norm_full;
  logic [MAG_W-1:0]        norm_sat;
  logic signed [VAL_W-1:0] q_s;
  logic signed [VAL_W-1:0] nxt;
  logic signed [VAL_W:0]   d_calc;
  logic signed [2*VAL_W+1:0] dsq;
  logic [ACC_W:0]          err_sum;
  logic                    sq_busy;
  logic                    chk_conv;
  logic                    chk_stop;
  logic                    mv_entry;
  logic                    div_run;

  // ---------------------------------------------------------------------------
  // Configuration port.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign tol_sq = tol_q * tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q  <= SIZE_RST;
      tol_q   <= TOL_RST;
      maxit_q <= MAXIT_RST;
    end else if (cfg_wr) begin
      case (reg_idx_e'(paddr[3:2]))
        REG_SIZE:  size_q  <= pwdata[SIZE_W-1:0];
        REG_TOL:   tol_q   <= pwdata[TOL_W-1:0];
        REG_MAXIT: maxit_q <= pwdata[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[3:2]))
      REG_SIZE:  prdata = 32'(size_q);
      REG_TOL:   prdata = 32'(tol_q);
      REG_MAXIT: prdata = 32'(maxit_q);
      default:   prdata = '0;
    endcase
  end

  // Squared tolerance follows the register; the user, not the block, must change it only while idle.
  always_ff @(posedge clk_i) begin
    tol2_q <= tol_sq;
  end

  // ---------------------------------------------------------------------------
  // Matrix store.
  // ---------------------------------------------------------------------------
  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;
  assign ram_we     = in_fire && ({1'b0, pos_q} < (POS_W + 1)'(DEPTH));

  pie_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pos_q[AW-1:0]),
    .wdata_i (in_data_i.value),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Vector chain: cell 0 is the head; the ring closes at cell n-1.
  // ---------------------------------------------------------------------------
  assign x_head = x_cell[0];
  assign y_head = y_cell[0];
  assign n_m1   = n_q - 1'b1;

  for (genvar k = 0; k < MAX_DIM; k++) begin : g_cell
    if (k == MAX_DIM - 1) begin : g_end
      assign x_nb[k] = '0;
      assign y_nb[k] = '0;
    end else begin : g_mid
      assign x_nb[k] = x_cell[k+1];
      assign y_nb[k] = y_cell[k+1];
    end

    pie_cell u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (cell_ctrl),
      .tail_i   (n_m1 == NW'(k)),
      .x_init_i (x_init),
      .x_ins_i  (x_ins),
      .x_next_i (x_nb[k]),
      .y_ins_i  (y_ins),
      .y_next_i (y_nb[k]),
      .x_o      (x_cell[k]),
      .y_o      (y_cell[k])
    );
  end

  // ---------------------------------------------------------------------------
  // Shared iterative units.
  // ---------------------------------------------------------------------------
  assign div_run   = (state_q == S_DIV) && (cnt_q != n_q);
  assign div_start = ((state_q == S_INIT) || div_run) && !dv_wait_q;
  assign div_dvd   = (state_q == S_INIT)
                   ? DVD_W'(32'h4000_0000 + 32'(n_q >> 1))
                   : {y_head.mag[SCL_W-1:0], {FRAC_SH{1'b0}}};
  assign div_dvs   = (state_q == S_INIT) ? ROOT_W'(n_q) : ns_q;

  pie_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quo_o      (div_quo)
  );

  pie_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (sum_q),
    .done_o     (sqrt_done),
    .root_o     (sqrt_root)
  );

  // ---------------------------------------------------------------------------
  // Datapath arithmetic.
  // ---------------------------------------------------------------------------
  always_comb begin
    if (size_q == '0) begin
      n_cl = SIZE_W'(1);
    end else if (size_q > SIZE_W'(MAX_DIM)) begin
      n_cl = SIZE_W'(MAX_DIM);
    end else begin
      n_cl = size_q;
    end
  end

  assign col_end = (NW'(col_q) == n_m1);
  assign row_end = (NW'(row_q) == n_m1);

  // Product divided by 64 with truncation toward zero, folded into the sum.
  assign p_sh    = p_q >>> PROD_SH;
  assign p_fix   = p_q[ACC_W-1] && (p_q[PROD_SH-1:0] != '0);
  assign acc_sum = acc_q + p_sh + {{(ACC_W-1){1'b0}}, p_fix};

  // Row result in sign-magnitude.
  assign yneg   = -yraw_q;
  assign ymag   = yraw_q[ACC_W-1] ? yneg[YMAG_W-1:0] : yraw_q[YMAG_W-1:0];
  assign bigger = (mag_q > big_q) ? mag_q : big_q;

  // Scaled magnitude and its square.
  assign sc_full = (y_head.mag >> rsh_q) << lsh_q;
  assign scaled  = sc_full[SCL_W-1:0];
  assign sc_sq   = scaled * scaled;
  assign sq_busy = (cnt_q != n_q);

  // Norm brought back to Q24.24 and saturated.
  assign root64    = ACC_W'(sqrt_root);
  assign rs_amt    = 7'(MAG_SH) - {1'b0, rsh_q} + {1'b0, lsh_q};
  assign norm_full = (rsh_q >= 6'(MAG_SH)) ? (root64 << (rsh_q - 6'(MAG_SH)))
                                           : (root64 >> rs_amt);
  assign norm_sat  = (norm_full > ACC_W'(MAG_SAT)) ? MAG_SAT : norm_full[MAG_W-1:0];

  // New x element and its distance from the old one.
  assign q_s     = {1'b0, div_quo};
  assign nxt     = y_head.neg ? -q_s : q_s;
  assign d_calc  = (VAL_W + 1)'(x_head) - (VAL_W + 1)'(nxt);
  assign dsq     = d_q * d_q;
  assign err_sum = {1'b0, err_q} + {1'b0, sqd_q};
  assign x_init  = {1'b0, div_quo};

  // Round-end decisions.
  assign chk_conv = (err_q <= ACC_W'(tol2_q));
  assign chk_stop = chk_conv || (iter_q >= maxit_q);
  assign mv_entry = ((state_q == S_INIT) && div_done) || ((state_q == S_CHK) && !chk_stop);

  assign sqrt_start = (state_q == S_SQ) && !sq_busy && !sqv_q;
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  // ---------------------------------------------------------------------------
  // Chain controls.
  // ---------------------------------------------------------------------------
  always_comb begin
    cell_ctrl.load_x  = (state_q == S_INIT) && div_done;
    cell_ctrl.shift_x = ((state_q == S_MV) && rv_q) || ((state_q == S_DIV) && div_done)
                      || out_load;
    cell_ctrl.shift_y = yv_q || ((state_q == S_SQ) && sq_busy)
                      || ((state_q == S_DIV) && div_done);
    x_ins = (state_q == S_DIV) ? nxt : x_head;
    case (state_q)
      S_SQ: begin
        y_ins.neg = y_head.neg;
        y_ins.mag = YMAG_W'(scaled);
      end
      S_DIV: begin
        y_ins = y_head;
      end
      default: begin
        y_ins.neg = yraw_q[ACC_W-1];
        y_ins.mag = ymag;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_fire && in_data_i.last_element) state_d = S_INIT;
      S_INIT: if (div_done) state_d = S_MV;
      S_MV:   if (mv_q && mlast_q) state_d = S_LOD;
      S_LOD: begin
        if (tmp_q == '0) begin
          state_d = S_OUT;
        end else if (tmp_q[YMAG_W-1:SCL_W] == '0 && tmp_q[SCL_W-1]) begin
          state_d = S_SQ;
        end
      end
      S_SQ:   if (sqrt_start) state_d = S_SQRT;
      S_SQRT: if (sqrt_done) state_d = S_DIV;
      S_DIV:  if (!div_run && !dv_wait_q && !dv_q && !sdv_q) state_d = S_CHK;
      S_CHK:  state_d = chk_stop ? S_OUT : S_MV;
      S_OUT:  if (out_load && cnt_q == n_m1) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= '0;
      n_q         <= NW'(1);
      row_q       <= '0;
      col_q       <= '0;
      addr_q      <= '0;
      issue_q     <= 1'b0;
      rv_q        <= 1'b0;
      rre_q       <= 1'b0;
      rlast_q     <= 1'b0;
      pv_q        <= 1'b0;
      pre_q       <= 1'b0;
      plast_q     <= 1'b0;
      yv_q        <= 1'b0;
      ylast_q     <= 1'b0;
      mv_q        <= 1'b0;
      mlast_q     <= 1'b0;
      sqv_q       <= 1'b0;
      dv_wait_q   <= 1'b0;
      dv_q        <= 1'b0;
      sdv_q       <= 1'b0;
      cnt_q       <= '0;
      iter_q      <= '0;
      conv_q      <= 1'b0;
      zero_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      // Multiply-accumulate pipeline tags.
      rv_q    <= issue_q;
      rre_q   <= col_end;
      rlast_q <= col_end && row_end;
      pv_q    <= rv_q;
      pre_q   <= rre_q;
      plast_q <= rlast_q;
      yv_q    <= pv_q && pre_q;
      ylast_q <= plast_q && pre_q;
      mv_q    <= yv_q;
      mlast_q <= ylast_q;
      sqv_q   <= (state_q == S_SQ) && sq_busy;
      dv_q    <= (state_q == S_DIV) && div_done;
      sdv_q   <= dv_q;

      // Output register.
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      // Load position and run start.
      if (in_fire) begin
        if (in_data_i.last_element) begin
          pos_q     <= '0;
          n_q       <= NW'(n_cl);
          iter_q    <= '0;
          conv_q    <= 1'b0;
          zero_q    <= 1'b0;
          dv_wait_q <= 1'b0;
        end else begin
          pos_q <= pos_q + 1'b1;
        end
      end

      // Matrix read sweep in row-major order.
      if (mv_entry) begin
        issue_q <= 1'b1;
        addr_q  <= '0;
        row_q   <= '0;
        col_q   <= '0;
      end else if (issue_q) begin
        addr_q <= addr_q + 1'b1;
        if (col_end) begin
          col_q <= '0;
          row_q <= row_q + 1'b1;
          if (row_end) begin
            issue_q <= 1'b0;
          end
        end else begin
          col_q <= col_q + 1'b1;
        end
      end

      // Divider handshake.
      if (div_start) begin
        dv_wait_q <= 1'b1;
      end else if (div_done) begin
        dv_wait_q <= 1'b0;
      end

      // Round bookkeeping and element counters.
      case (state_q)
        S_MV: begin
          if (mv_q && mlast_q) begin
            iter_q <= iter_q + 1'b1;
          end
        end
        S_LOD: begin
          cnt_q <= '0;
          if (tmp_q == '0) begin
            zero_q <= 1'b1;
          end
        end
        S_SQ: begin
          if (sq_busy) begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_SQRT: begin
          cnt_q <= '0;
        end
        S_DIV: begin
          if (div_done) begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_CHK: begin
          cnt_q <= '0;
          if (chk_conv) begin
            conv_q <= 1'b1;
          end
        end
        S_OUT: begin
          if (out_load) begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    // Multiply stage: matrix element times the x element at the ring head.
    if (rv_q) begin
      p_q <= ram_rdata * x_head;
    end

    // Row accumulation.
    if (mv_entry) begin
      acc_q <= '0;
    end else if (pv_q) begin
      if (pre_q) begin
        yraw_q <= acc_sum;
        acc_q  <= '0;
      end else begin
        acc_q <= acc_sum;
      end
    end

    // Largest magnitude over the rows.
    if (yv_q) begin
      mag_q <= ymag;
    end
    if (mv_entry) begin
      big_q <= '0;
    end else if (mv_q) begin
      big_q <= bigger;
    end

    // Normalizing shift search, one bit per cycle.
    if (mv_q && mlast_q) begin
      tmp_q <= bigger;
      rsh_q <= '0;
      lsh_q <= '0;
    end else if (state_q == S_LOD && tmp_q != '0) begin
      if (tmp_q[YMAG_W-1:SCL_W] != '0) begin
        tmp_q <= tmp_q >> 1;
        rsh_q <= rsh_q + 1'b1;
      end else if (!tmp_q[SCL_W-1]) begin
        tmp_q <= tmp_q << 1;
        lsh_q <= lsh_q + 1'b1;
      end
    end

    // Sum of squares of the scaled vector.
    if (state_q == S_SQ && sq_busy) begin
      sq_q <= sc_sq;
    end
    if (state_q == S_LOD) begin
      sum_q <= '0;
    end else if (sqv_q) begin
      sum_q <= sum_q + ACC_W'(sq_q);
    end

    // Norm, with the zero-vector case reporting zero.
    if (state_q == S_LOD && tmp_q == '0) begin
      norm_q <= '0;
    end else if (sqrt_done) begin
      ns_q   <= sqrt_root;
      norm_q <= norm_sat;
    end

    // Squared distance between successive vectors, saturating.
    if (div_done) begin
      d_q <= d_calc;
    end
    if (dv_q) begin
      sqd_q <= dsq[ACC_W-1:0];
    end
    if (mv_entry) begin
      err_q <= '0;
    end else if (sdv_q) begin
      err_q <= err_sum[ACC_W] ? {ACC_W{1'b1}} : err_sum[ACC_W-1:0];
    end

    // Result item.
    if (out_load) begin
      out_q.vector_element  <= zero_q ? '0 : x_head;
      out_q.eigen_magnitude <= norm_q;
      out_q.iterations      <= iter_q;
      out_q.converged       <= conv_q;
      out_q.last_result     <= (cnt_q == n_m1);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for power_iteration_eigen_engine_core: streams matrices,
// predicts every eigenvector result in fixed point, and checks each result item.
// Depends on pie_pkg and the core RTL.
module tb_top;
  import pie_pkg::*;

  localparam int unsigned DIM = 64;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // Kinds of matrix content.
  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_IDENTITY, FILL_EXTREME} fill_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // Items waiting to be driven and results waiting to be seen.
  in_item_t elem_pending[$];
  out_item_t eigen_expected[$];
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned written_top = 0;

  // Mirror of the block's registers and storage.
  logic [SIZE_W-1:0] size_reg = SIZE_RST;
  logic [TOL_W-1:0] tol_reg = TOL_RST;
  logic [ITER_W-1:0] maxit_reg = MAXIT_RST;
  logic signed [31:0] mat_mem[DIM*DIM];
  logic signed [31:0] x_vec[DIM];
  logic [POS_W-1:0] load_pos = '0;

  power_iteration_eigen_engine_core #(.MAX_DIM(DIM)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned eff_dim();
    if (size_reg == 0) return 1;
    if (size_reg > DIM) return DIM;
    return size_reg;
  endfunction

  // Floor square root, bit by bit.
  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Runs the power method on the mirrored matrix and queues the n result items.
  task automatic predict_eigen();
    longint unsigned mag[DIM];
    bit neg[DIM];
    int unsigned n, i, j, rsh, lsh, iters;
    longint acc, q, d;
    longint unsigned big, sum, ns, err, sq, tol2, norm;
    logic signed [31:0] nxt;
    bit conv;
    out_item_t r;
    n = eff_dim();
    tol2 = longint'(tol_reg) * longint'(tol_reg);
    iters = 0;
    conv = 0;
    norm = 0;
    for (i = 0; i < n; i++) x_vec[i] = ((32'd1 << 30) + n / 2) / n;
    forever begin
      big = 0;
      sum = 0;
      err = 0;
      rsh = 0;
      lsh = 0;
      for (i = 0; i < n; i++) begin
        acc = 0;
        for (j = 0; j < n; j++)
          acc += (longint'(mat_mem[i*n+j]) * longint'(x_vec[j])) / 64;
        neg[i] = acc < 0;
        mag[i] = neg[i] ? -acc : acc;
        if (mag[i] > big) big = mag[i];
      end
      iters++;
      if (big == 0) begin
        for (i = 0; i < n; i++) x_vec[i] = 0;
        norm = 0;
        break;
      end
      while ((big >> rsh) >= (64'd1 << 28)) rsh++;
      while ((big << lsh) < (64'd1 << 27)) lsh++;
      for (i = 0; i < n; i++) begin
        mag[i] = (mag[i] >> rsh) << lsh;
        sum += mag[i] * mag[i];
      end
      ns = floor_sqrt(sum);
      if (rsh >= 24) norm = ns << (rsh - 24);
      else norm = ns >> (24 - rsh + lsh);
      if (norm > {16'd0, MAG_SAT}) norm = {16'd0, MAG_SAT};
      for (i = 0; i < n; i++) begin
        q = (mag[i] << 30) / ns;
        nxt = neg[i] ? -q : q;
        d = longint'(x_vec[i]) - longint'(nxt);
        sq = d * d;
        err = (err > ~64'd0 - sq) ? ~64'd0 : err + sq;
        x_vec[i] = nxt;
      end
      if (err <= tol2) begin
        conv = 1;
        break;
      end
      if (iters >= maxit_reg) break;
    end
    for (i = 0; i < n; i++) begin
      r.vector_element = x_vec[i];
      r.eigen_magnitude = norm[MAG_W-1:0];
      r.iterations = iters[ITER_W-1:0];
      r.converged = conv;
      r.last_result = (i == n - 1);
      eigen_expected.push_back(r);
    end
  endtask

  task automatic report(string what, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // Driver: presents pending items, holding each until accepted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (elem_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= elem_pending.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Mirror of each accepted matrix element; the last one starts the prediction.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid && in_ready) begin
      mat_mem[load_pos] = in_data.value;
      load_pos = load_pos + 1'b1;
      if (in_data.last_element) begin
        load_pos = '0;
        predict_eigen();
      end
    end
  end

  // Monitor: random back-pressure and field-by-field comparison.
  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni) begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
      if (out_valid && out_ready) begin
        if (eigen_expected.size() == 0) begin
          report("unexpected result", 64'(out_data.vector_element), 0);
        end else begin
          e = eigen_expected.pop_front();
          if (out_data.vector_element !== e.vector_element)
            report("vector_element", out_data.vector_element, e.vector_element);
          if (out_data.eigen_magnitude !== e.eigen_magnitude)
            report("eigen_magnitude", out_data.eigen_magnitude, e.eigen_magnitude);
          if (out_data.iterations !== e.iterations)
            report("iterations", out_data.iterations, e.iterations);
          if (out_data.converged !== e.converged)
            report("converged", out_data.converged, e.converged);
          if (out_data.last_result !== e.last_result)
            report("last_result", out_data.last_result, e.last_result);
        end
      end
    end
  end

  // APB write: setup cycle then access cycle; the mirror follows.
  task automatic cfg_write(logic [1:0] idx, logic [31:0] v);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SIZE: size_reg = v[SIZE_W-1:0];
      REG_TOL: tol_reg = v[TOL_W-1:0];
      REG_MAXIT: maxit_reg = v[ITER_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_cfg(int unsigned sz, int unsigned tol, int unsigned maxit);
    cfg_write(REG_SIZE, sz);
    cfg_write(REG_TOL, tol);
    cfg_write(REG_MAXIT, maxit);
  endtask

  // Queues cnt elements of a matrix; the last carries the start flag.
  task automatic load_matrix(int unsigned cnt, fill_e kind);
    int unsigned k, n;
    in_item_t it;
    n = eff_dim();
    for (k = 0; k < cnt; k++) begin
      case (kind)
        FILL_ZERO: it.value = 0;
        FILL_IDENTITY: it.value = ((k / n) == (k % n)) ? (32'sd1 <<< 24) : 0;
        FILL_EXTREME: it.value = k[0] ? 32'h7fffffff : 32'h80000000;
        default: begin
          case ($urandom_range(3))
            0: it.value = $urandom_range(32'h03ffffff) - 32'sh02000000;
            1: it.value = 0;
            default: it.value = $urandom;
          endcase
        end
      endcase
      it.last_element = (k == cnt - 1);
      elem_pending.push_back(it);
    end
    if (cnt > written_top) written_top = cnt;
  endtask

  // Waits until the block is quiet, then a few more cycles.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (elem_pending.size() > 0 || in_valid || eigen_expected.size() > 0);
    repeat (16) @(negedge clk_i);
  endtask

  task automatic set_idling(int unsigned mode);
    case (mode % 4)
      0: begin send_idle_pct = 0; recv_stall_pct = 0; end
      1: begin send_idle_pct = 65; recv_stall_pct = 0; end
      2: begin send_idle_pct = 0; recv_stall_pct = 65; end
      default: begin send_idle_pct = 24; recv_stall_pct = 24; end
    endcase
  endtask

  // Main sequence: directed cases, random runs, then a larger dimension.
  initial begin
    int unsigned run, n, cnt, sent;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single element at the most negative value, then again with one extra item at the most positive.
    set_cfg(1, 0, 3);
    load_matrix(1, FILL_EXTREME);
    wait_idle();
    load_matrix(2, FILL_EXTREME);
    wait_idle();
    // Zero matrix gives a zero norm.
    set_cfg(2, 1, 5);
    load_matrix(4, FILL_ZERO);
    wait_idle();
    // Cap of zero stops after one round.
    set_cfg(2, 0, 0);
    load_matrix(4, FILL_IDENTITY);
    wait_idle();
    // Dimension zero acts as one; a write to an unused index is ignored.
    cfg_write(REG_UNUSED, 32'hffffffff);
    set_cfg(0, 1 << 30, 1);
    load_matrix(1, FILL_RANDOM);
    wait_idle();
    // Extreme cap with a matrix that converges at once.
    set_cfg(3, 1 << 30, 65535);
    load_matrix(9, FILL_IDENTITY);
    wait_idle();

    // Random runs over small dimensions.
    sent = 0;
    run = 0;
    while (sent < 140) begin
      set_idling(run);
      n = ($urandom_range(9) == 0) ? 8 : $urandom_range(1, 6);
      case ($urandom_range(3))
        0: cfg_write(REG_TOL, $urandom_range(0, 1 << 30));
        1: cfg_write(REG_TOL, $urandom_range(0, 1 << 16));
        default: cfg_write(REG_TOL, $urandom_range(0, 64));
      endcase
      cfg_write(REG_SIZE, n);
      cfg_write(REG_MAXIT, $urandom_range(0, 12));
      cnt = n * n;
      case ($urandom_range(9))
        0: cnt = cnt + $urandom_range(1, 3);
        1: if (cnt > 1 && written_top >= cnt) cnt = $urandom_range(1, cnt - 1);
        default: ;
      endcase
      load_matrix(cnt, ($urandom_range(7) == 0) ? FILL_IDENTITY : FILL_RANDOM);
      sent += cnt;
      run++;
      wait_idle();
    end

    // A larger dimension under mixed idling.
    set_idling(3);
    set_cfg(10, 0, 1);
    load_matrix(100, FILL_RANDOM);
    wait_idle();

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog for a hung run.
  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

endmodule

### sim.f
rtl/core/pie_pkg.sv
rtl/core/pie_ram.sv
rtl/core/pie_cell.sv
rtl/core/pie_div.sv
rtl/core/pie_sqrt.sv
rtl/core/power_iteration_eigen_engine_core.sv
sim/tb_top.sv
